// ===== rtl/msms_pkg.sv =====
package msms_pkg;

  localparam int RATE_W      = 9;
  localparam int OX_W        = 7;
  localparam int RATE_T_W    = 13;
  localparam int OX_T_W      = 11;
  localparam int RCNT_W      = 5;
  localparam int PHASE_W     = 3;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DETECT  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CALIB   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_COLLECT = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SEND    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DISPLAY = 3'd5;
  localparam logic [PHASE_W-1:0] PH_REPOS   = 3'd6;

  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SHUT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_AUTO_RESTART  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_READINGS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_TARGET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT    = 3'd4;

  typedef struct packed {
    logic ins;
    logic valid;
  } cell_ctrl_t;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic                valid;
    logic [RATE_T_W-1:0] rate;
    logic [OX_T_W-1:0]   ox;
    logic [RCNT_W-1:0]   cnt;
    logic [CMD_W-1:0]    cmd;
  } result_t;

endpackage

// ===== rtl/msms_sort_cell.sv =====
module msms_sort_cell #(
  parameter int W = 9
) (
  input  logic                  clk_i,
  input  msms_pkg::cell_ctrl_t  ctrl_i,
  input  logic [W-1:0]          new_i,
  input  logic [W-1:0]          prev_i,
  input  logic                  prev_gt_i,
  output logic [W-1:0]          value_o,
  output logic                  gt_o
);

  logic [W-1:0] value_q, value_d;

  assign gt_o    = ctrl_i.valid && (value_q > new_i);
  assign value_o = value_q;

  // Cells above the insertion point take their left neighbor's value.
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (prev_gt_i) begin
        value_d = prev_i;
      end else if (gt_o || !ctrl_i.valid) begin
        value_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== rtl/msms_sort_chain.sv =====
module msms_sort_chain #(
  parameter int DEPTH = 32,
  parameter int W     = 9,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          insert_i,
  input  logic [CW-1:0] count_i,
  input  logic [W-1:0]  data_i,
  input  logic [IW-1:0] rd_idx_i,
  output logic [W-1:0]  rd_data_o
);

  logic [W-1:0] vals [DEPTH];
  logic         gts  [DEPTH];
  logic [W-1:0] rd_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    msms_pkg::cell_ctrl_t ctrl;
    logic [W-1:0]         prev;
    logic                 prev_gt;
    assign ctrl.ins   = insert_i;
    assign ctrl.valid = count_i > CW'(i);
    if (i == 0) begin : g_head
      assign prev    = '0;
      assign prev_gt = 1'b0;
    end else begin : g_body
      assign prev    = vals[i-1];
      assign prev_gt = gts[i-1];
    end
    msms_sort_cell #(.W(W)) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .new_i     (data_i),
      .prev_i    (prev),
      .prev_gt_i (prev_gt),
      .value_o   (vals[i]),
      .gt_o      (gts[i])
    );
  end

  always_ff @(posedge clk_i) begin
    rd_q <= vals[rd_idx_i];
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/msms_div.sv =====
module msms_div #(
  parameter int NW = 17,
  parameter int D  = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int SH = NW + $clog2(D);
  localparam int MW = SH + 1;
  localparam int PW = NW + MW;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);

  logic [PW-1:0] prod;
  logic [NW-1:0] quo_q;
  logic          done_q;

  // Multiplying by the rounded-up reciprocal gives the exact quotient for
  // every numerator of NW bits, since the scale has log2(D) spare bits.
  assign prod = PW'(num_i) * PW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= prod[SH +: NW];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/measurement_settle_median_sequencer_top.sv =====
// Session sequencer for a pulse-oximeter reading, advanced once per tick word.
// Input channel: one tick word (operation, finger flag, reading flags, heart
// rate, SpO2) per accepted word, taken when in_valid_i is high and in_stall_o
// is low. Each tick word yields exactly one result word on the output channel.
// An ordinary tick passes through the work and put states into the output
// register, and the next word can be taken once the result is loaded there.
// A median send tick adds the MEDA, MEDB and MEDC states (two registered
// reads of the sorted cell rows), a stable send tick adds the DIV state (the
// reciprocal multiply of the mean); a send tick with no readings adds none.
// Words are processed one at a time; in_stall_o stays high until the result
// is loaded. Readings are kept in two rows of sorting cells that insert each
// new value in place, so the medians are read straight from the middle cells.
// The output register holds a result while out_stall_i is high; the next
// tick word is still taken and worked on, and waits until the register frees.
// Configuration writes are always ready and take effect at once; write them
// only while the block is idle. Reset puts the sequence in the idle phase and
// loads the register defaults; the reading store needs no clearing.
module measurement_settle_median_sequencer_top #(
  parameter int STORE_DEPTH = 32,
  parameter int WINDOW      = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic                             finger_present_i,
  input  logic                             rate_ok_i,
  input  logic                             oxygen_ok_i,
  input  logic [msms_pkg::RATE_W-1:0]      heart_rate_i,
  input  logic [msms_pkg::OX_W-1:0]        oxygen_level_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [msms_pkg::PHASE_W-1:0]     phase_o,
  output logic                             report_valid_o,
  output logic [msms_pkg::RATE_T_W-1:0]    report_rate_tenths_o,
  output logic [msms_pkg::OX_T_W-1:0]      report_oxygen_tenths_o,
  output logic [msms_pkg::RCNT_W-1:0]      report_count_o,
  output logic [msms_pkg::CMD_W-1:0]       sensor_command_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [msms_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [msms_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int RW  = msms_pkg::RATE_W;
  localparam int OW  = msms_pkg::OX_W;
  localparam int CW  = $clog2(STORE_DEPTH + 1);
  localparam int IW  = $clog2(STORE_DEPTH);
  localparam int SW  = $clog2(WINDOW * ((1 << RW) - 1) + 1);
  localparam int NW  = SW + 5;

  localparam logic [2:0] CS_READY = 3'd0;
  localparam logic [2:0] CS_WORK  = 3'd1;
  localparam logic [2:0] CS_MEDA  = 3'd2;
  localparam logic [2:0] CS_MEDB  = 3'd3;
  localparam logic [2:0] CS_MEDC  = 3'd4;
  localparam logic [2:0] CS_DIV   = 3'd5;
  localparam logic [2:0] CS_PUT   = 3'd6;

  logic [2:0] ctrl_q, ctrl_d;

  // Configuration registers.
  logic       auto_restart_q;
  logic [7:0] display_ticks_q;
  logic [4:0] max_readings_q;
  logic [7:0] delta_target_q;
  logic [8:0] rate_limit_q;

  // Sequence state.
  logic [msms_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         stable_q, stable_d;
  logic [SW-1:0]                rsum_q, rsum_d;
  logic [OW-1:0]                stox_q, stox_d;
  logic [7:0]                   disp_q, disp_d;

  // Latched tick word.
  logic          op_q, finger_q, rok_q, ook_q;
  logic [RW-1:0] hr_q;
  logic [OW-1:0] ox_q;

  logic [RW-1:0] hist_q [WINDOW+1];
  logic [RW-1:0] tap    [WINDOW+1];

  msms_pkg::result_t res_q, res_d, out_q;
  logic              out_valid_q;
  logic [RW-1:0]     lo_rate_q;
  logic [OW-1:0]     lo_ox_q;

  logic          ins;
  logic          stored;
  logic [CW-1:0] cnt_new;
  logic [SW-1:0] dsum, rsum;
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] lo_full, hi_full;
  logic [RW-1:0] rd_rate;
  logic [OW-1:0] rd_ox;
  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [RW:0]   rate_pair;
  logic [OW:0]   ox_pair;
  logic          load;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (ctrl_q != CS_READY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_restart_q  <= 1'b0;
      display_ticks_q <= 8'd30;
      max_readings_q  <= 5'd30;
      delta_target_q  <= 8'd3;
      rate_limit_q    <= 9'd160;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        msms_pkg::REG_AUTO_RESTART:  auto_restart_q  <= cfg_data_i[0];
        msms_pkg::REG_DISPLAY_TICKS: display_ticks_q <= cfg_data_i[7:0];
        msms_pkg::REG_MAX_READINGS:  max_readings_q  <= cfg_data_i[4:0];
        msms_pkg::REG_DELTA_TARGET:  delta_target_q  <= cfg_data_i[7:0];
        msms_pkg::REG_RATE_LIMIT:    rate_limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Window view after this tick's reading is appended.
  assign stored  = cnt_q < CW'(STORE_DEPTH);
  assign cnt_new = stored ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    for (int k = 0; k <= WINDOW; k++) begin
      if (!stored) begin
        tap[k] = hist_q[k];
      end else if (k == 0) begin
        tap[k] = hr_q;
      end else begin
        tap[k] = hist_q[k-1];
      end
    end
  end

  always_comb begin
    dsum = '0;
    rsum = '0;
    for (int k = 0; k < WINDOW; k++) begin
      dsum = dsum + SW'((tap[k] > tap[k+1]) ? tap[k] - tap[k+1] : tap[k+1] - tap[k]);
      rsum = rsum + SW'(tap[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins) begin
      hist_q[0] <= hr_q;
      for (int k = 1; k <= WINDOW; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  assign lo_full = (cnt_q - 1'b1) >> 1;
  assign hi_full = cnt_q >> 1;
  assign rd_idx  = (ctrl_q == CS_MEDA) ? lo_full[IW-1:0] : hi_full[IW-1:0];

  msms_sort_chain #(.DEPTH(STORE_DEPTH), .W(RW)) u_rate_row (
    .clk_i     (clk_i),
    .insert_i  (ins),
    .count_i   (cnt_q),
    .data_i    (hr_q),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_rate)
  );

  msms_sort_chain #(.DEPTH(STORE_DEPTH), .W(OW)) u_ox_row (
    .clk_i     (clk_i),
    .insert_i  (ins),
    .count_i   (cnt_q),
    .data_i    (ox_q),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_ox)
  );

  // Rounded mean in tenths: (rsum * 20 + WINDOW) / (2 * WINDOW).
  assign div_num = (NW'(rsum_q) << 4) + (NW'(rsum_q) << 2) + NW'(WINDOW);

  msms_div #(.NW(NW), .D(2 * WINDOW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign rate_pair = {1'b0, lo_rate_q} + {1'b0, rd_rate};
  assign ox_pair   = {1'b0, lo_ox_q} + {1'b0, rd_ox};

  always_comb begin
    ctrl_d    = ctrl_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    stable_d  = stable_q;
    rsum_d    = rsum_q;
    stox_d    = stox_q;
    disp_d    = disp_q;
    res_d     = res_q;
    ins       = 1'b0;
    div_start = 1'b0;
    unique case (ctrl_q)
      CS_READY: begin
        if (in_valid_i) begin
          ctrl_d = CS_WORK;
        end
      end
      CS_WORK: begin
        ctrl_d = CS_PUT;
        res_d  = '0;
        if (op_q) begin
          phase_d   = msms_pkg::PH_DETECT;
          stable_d  = 1'b0;
          res_d.cmd = msms_pkg::CMD_INIT;
        end else begin
          case (phase_q)
            msms_pkg::PH_DETECT: begin
              if (finger_q) begin
                phase_d = msms_pkg::PH_CALIB;
              end
            end
            msms_pkg::PH_CALIB: begin
              stable_d = 1'b0;
              if (!rok_q || !ook_q || (hr_q > rate_limit_q)) begin
                phase_d   = msms_pkg::PH_REPOS;
                res_d.cmd = msms_pkg::CMD_INIT;
              end else begin
                cnt_d   = '0;
                phase_d = msms_pkg::PH_COLLECT;
              end
            end
            msms_pkg::PH_REPOS: begin
              phase_d = msms_pkg::PH_DETECT;
            end
            msms_pkg::PH_COLLECT: begin
              if (!rok_q || !ook_q) begin
                phase_d   = msms_pkg::PH_REPOS;
                stable_d  = 1'b0;
                res_d.cmd = msms_pkg::CMD_INIT;
              end else begin
                ins   = stored;
                cnt_d = cnt_new;
                if ((cnt_new > CW'(WINDOW)) && (dsum <= SW'(delta_target_q))) begin
                  stable_d = 1'b1;
                  rsum_d   = rsum;
                  stox_d   = ox_q;
                  phase_d  = msms_pkg::PH_SEND;
                end
                if ((int'(cnt_new) > int'(max_readings_q)) ||
                    (cnt_new >= CW'(STORE_DEPTH))) begin
                  phase_d = msms_pkg::PH_SEND;
                end
              end
            end
            msms_pkg::PH_SEND: begin
              res_d.valid = 1'b1;
              res_d.cmd   = msms_pkg::CMD_SHUT;
              res_d.cnt   = (cnt_q == '0) ? '0 : msms_pkg::RCNT_W'(cnt_q - 1'b1);
              phase_d     = msms_pkg::PH_DISPLAY;
              disp_d      = display_ticks_q;
              if (stable_q) begin
                res_d.ox  = (msms_pkg::OX_T_W'(stox_q) << 3) +
                            (msms_pkg::OX_T_W'(stox_q) << 1);
                div_start = 1'b1;
                ctrl_d    = CS_DIV;
              end else if (cnt_q != '0) begin
                ctrl_d = CS_MEDA;
              end
            end
            msms_pkg::PH_DISPLAY: begin
              disp_d = disp_q - 1'b1;
              if (disp_d == 8'd0) begin
                if (auto_restart_q) begin
                  stable_d  = 1'b0;
                  res_d.cmd = msms_pkg::CMD_INIT;
                  phase_d   = msms_pkg::PH_DETECT;
                end else begin
                  phase_d = msms_pkg::PH_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
        res_d.phase = phase_d;
      end
      CS_MEDA: ctrl_d = CS_MEDB;
      CS_MEDB: ctrl_d = CS_MEDC;
      CS_MEDC: begin
        // Odd counts read the same middle cell twice, so (lo + hi) * 5 holds.
        res_d.rate = (msms_pkg::RATE_T_W'(rate_pair) << 2) + msms_pkg::RATE_T_W'(rate_pair);
        res_d.ox   = (msms_pkg::OX_T_W'(ox_pair) << 2) + msms_pkg::OX_T_W'(ox_pair);
        ctrl_d     = CS_PUT;
      end
      CS_DIV: begin
        if (div_done) begin
          res_d.rate = div_quo[msms_pkg::RATE_T_W-1:0];
          ctrl_d     = CS_PUT;
        end
      end
      CS_PUT: begin
        if (load) begin
          ctrl_d = CS_READY;
        end
      end
      default: ctrl_d = CS_READY;
    endcase
  end

  assign load = (ctrl_q == CS_PUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= CS_READY;
      phase_q     <= msms_pkg::PH_IDLE;
      cnt_q       <= '0;
      stable_q    <= 1'b0;
      rsum_q      <= '0;
      stox_q      <= '0;
      disp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ctrl_q   <= ctrl_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      stable_q <= stable_d;
      rsum_q   <= rsum_d;
      stox_q   <= stox_d;
      disp_q   <= disp_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (ctrl_q == CS_READY && in_valid_i) begin
      op_q     <= operation_i;
      finger_q <= finger_present_i;
      rok_q    <= rate_ok_i;
      ook_q    <= oxygen_ok_i;
      hr_q     <= heart_rate_i;
      ox_q     <= oxygen_level_i;
    end
    if (ctrl_q == CS_MEDB) begin
      lo_rate_q <= rd_rate;
      lo_ox_q   <= rd_ox;
    end
    if (load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign phase_o                = out_q.phase;
  assign report_valid_o         = out_q.valid;
  assign report_rate_tenths_o   = out_q.rate;
  assign report_oxygen_tenths_o = out_q.ox;
  assign report_count_o         = out_q.cnt;
  assign sensor_command_o       = out_q.cmd;

endmodule
